// ----- hw/rtl/tcs_pkg.sv -----
// Shared types and constants of the triangle cull, shade and projection pipeline.
package tcs_pkg;

	localparam int COORD_W  = 24;
	localparam int DEPTH_W  = 25;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 3;
	localparam int SQ_W     = 62;
	localparam int LEN_W    = 31;
	localparam int SQRT_STEPS = 31;

	localparam logic signed [DEPTH_W-1:0] DEPTH_BIAS = 25'sd327680;
	localparam logic signed [DEPTH_W-1:0] DEPTH_MIN  = 25'sd6554;
	localparam logic signed [16:0] LIGHT_X = 17'sd39126;
	localparam logic signed [16:0] LIGHT_Y = -17'sd26084;
	localparam logic signed [16:0] LIGHT_Z = 17'sd45648;
	localparam logic [SQ_W-1:0] TINY_SQ = 62'd184467440737;
	localparam logic [17:0] BRIGHT_BASE = 18'd16384;
	localparam logic [15:0] BRIGHT_GAIN = 16'd49152;
	localparam logic [25:0] MEAN_RECIP = 26'd44739243;
	localparam logic [23:0] MEAN_MAX = 24'h7FFFFF;

	localparam logic [23:0] FOCAL_RESET = 24'd65536;
	localparam logic [23:0] SCALE_RESET = 24'd65536;
	localparam logic [15:0] COLOR_RESET = 16'hFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FOCAL    = 3'd0,
		CFG_SCALE    = 3'd1,
		CFG_X_OFFSET = 3'd2,
		CFG_Y_OFFSET = 3'd3,
		CFG_BASE     = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0]        face_id;
		logic signed [23:0] ax;
		logic signed [23:0] ay;
		logic signed [23:0] az;
		logic signed [23:0] bx;
		logic signed [23:0] by_coord;
		logic signed [23:0] bz;
		logic signed [23:0] cx;
		logic signed [23:0] cy;
		logic signed [23:0] cz;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        tri_id;
		logic signed [15:0] pax;
		logic signed [15:0] pay;
		logic signed [15:0] pbx;
		logic signed [15:0] pby;
		logic signed [15:0] pcx;
		logic signed [15:0] pcy;
		logic signed [23:0] mean_depth;
		logic [15:0]        shaded_color;
	} result_t;

endpackage

// ----- hw/rtl/tcs_delay.sv -----
// Fixed-length delay line for pipeline side data.
module tcs_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_s [1:D];

	always_ff @(posedge clk) begin
		tap_s[1] <= din;
		for (int i = 2; i <= D; i++) begin
			tap_s[i] <= tap_s[i-1];
		end
	end

	assign dout = tap_s[D];

endmodule

// ----- hw/rtl/tcs_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
module tcs_div #(
	parameter int NW = 48,
	parameter int DW = 24,
	parameter int QW = 18
) (
	input  logic          clk,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int RW = (NW > DW + QW) ? NW : DW + QW;

	logic [RW-1:0] rem_s [1:QW];
	logic [DW-1:0] den_s [1:QW];
	logic [QW-1:0] quo_s [1:QW];

	for (genvar j = 0; j < QW; j++) begin : g_stage
		logic [RW-1:0] r_in;
		logic [DW-1:0] d_in;
		logic [QW-1:0] q_in;
		logic [RW-1:0] trial;
		logic          ge;

		if (j == 0) begin : g_first
			assign r_in = RW'(num);
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[j];
			assign d_in = den_s[j];
			assign q_in = quo_s[j];
		end

		assign trial = RW'(d_in) << (QW - 1 - j);
		assign ge    = (r_in >= trial);

		always_ff @(posedge clk) begin
			rem_s[j+1] <= ge ? r_in - trial : r_in;
			den_s[j+1] <= d_in;
			quo_s[j+1] <= {q_in[QW-2:0], ge};
		end
	end

	assign quo = quo_s[QW];

endmodule

// ----- hw/rtl/tcs_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module tcs_isqrt (
	input  logic                      clk,
	input  logic [tcs_pkg::SQ_W-1:0]  sq,
	output logic [tcs_pkg::LEN_W-1:0] root
);

	localparam int N = tcs_pkg::SQRT_STEPS;
	localparam int SW = tcs_pkg::SQ_W;

	logic [SW-1:0] rem_s [1:N];
	logic [SW-1:0] res_s [1:N];

	for (genvar j = 0; j < N; j++) begin : g_stage
		logic [SW-1:0] r_in;
		logic [SW-1:0] q_in;
		logic [SW-1:0] bitv;
		logic [SW-1:0] trial;
		logic          ge;

		if (j == 0) begin : g_first
			assign r_in = sq;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[j];
			assign q_in = res_s[j];
		end

		assign bitv  = SW'(1) << (2 * (N - 1 - j));
		assign trial = q_in + bitv;
		assign ge    = (r_in >= trial);

		always_ff @(posedge clk) begin
			rem_s[j+1] <= ge ? r_in - trial : r_in;
			res_s[j+1] <= ge ? (q_in >> 1) + bitv : (q_in >> 1);
		end
	end

	assign root = res_s[N][tcs_pkg::LEN_W-1:0];

endmodule

// ----- hw/rtl/triangle_cull_shade_project.sv -----
// Top level: triangle cull, flat shade and perspective projection pipeline.
// One triangle is taken on every clock at which start is high; busy never rises. A visible
// triangle gives its result on the result port, marked by done for one cycle; a culled
// triangle gives nothing. The receiver cannot hold results off, so each result must be
// captured in the cycle that done shows it. The latency is set by the chain of the normal's
// integer square root (31 stages) and the light divide (18 stages), both one bit per stage;
// the six projection divides (35 stages) run beside them. Registers should be written only
// while no triangle is in flight.
module triangle_cull_shade_project #(
	parameter int SCREEN_WIDTH  = 240,
	parameter int SCREEN_HEIGHT = 320
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  tcs_pkg::in_item_t               in_item,
	input  logic                            cfg_we,
	input  logic [tcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tcs_pkg::CFG_W-1:0]       cfg_data,
	output logic                            done,
	output tcs_pkg::result_t                result
);

	localparam int PQ_W   = 35;
	localparam int DL_W   = 18;
	localparam int S_LEN  = 9 + tcs_pkg::SQRT_STEPS;
	localparam int S_DL   = S_LEN + DL_W;
	localparam int LAST   = S_DL + 2;
	localparam int S_PROJ = 3 + PQ_W + 4;

	logic [23:0]        focal_length_q;
	logic [23:0]        scale_q;
	logic signed [10:0] x_offset_q;
	logic signed [10:0] y_offset_q;
	logic [15:0]        base_color_q;

	logic valid_s [1:LAST];
	logic cull_s7;
	logic accept;

	assign accept = start && !busy;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_length_q <= tcs_pkg::FOCAL_RESET;
			scale_q        <= tcs_pkg::SCALE_RESET;
			x_offset_q     <= '0;
			y_offset_q     <= '0;
			base_color_q   <= tcs_pkg::COLOR_RESET;
		end else if (cfg_we) begin
			case (tcs_pkg::cfg_idx_t'(cfg_index))
				tcs_pkg::CFG_FOCAL:    focal_length_q <= cfg_data;
				tcs_pkg::CFG_SCALE:    scale_q        <= cfg_data;
				tcs_pkg::CFG_X_OFFSET: x_offset_q     <= cfg_data[10:0];
				tcs_pkg::CFG_Y_OFFSET: y_offset_q     <= cfg_data[10:0];
				tcs_pkg::CFG_BASE:     base_color_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// advance valid bits; drop culled transactions at stage 8
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAST; i++) begin
				valid_s[i] <= 1'b0;
			end
		end else begin
			valid_s[1] <= accept;
			for (int i = 2; i <= LAST; i++) begin
				valid_s[i] <= (i == 8) ? (valid_s[i-1] && !cull_s7) : valid_s[i-1];
			end
		end
	end

	// stage 1: depths and edge vectors
	logic signed [24:0] da_s1, db_s1, dc_s1;
	logic signed [24:0] v1x_s1, v1y_s1, v1z_s1, v2x_s1, v2y_s1, v2z_s1;
	logic signed [23:0] vert_s1 [6];
	logic               depth_ok_s1;
	logic [15:0]        face_id_s1;
	logic signed [24:0] da_s1_next, db_s1_next, dc_s1_next;

	always_comb begin
		da_s1_next = in_item.az + tcs_pkg::DEPTH_BIAS;
		db_s1_next = in_item.bz + tcs_pkg::DEPTH_BIAS;
		dc_s1_next = in_item.cz + tcs_pkg::DEPTH_BIAS;
	end

	always_ff @(posedge clk) begin
		da_s1  <= da_s1_next;
		db_s1  <= db_s1_next;
		dc_s1  <= dc_s1_next;
		v1x_s1 <= in_item.bx - in_item.ax;
		v1y_s1 <= in_item.by_coord - in_item.ay;
		v1z_s1 <= in_item.bz - in_item.az;
		v2x_s1 <= in_item.cx - in_item.ax;
		v2y_s1 <= in_item.cy - in_item.ay;
		v2z_s1 <= in_item.cz - in_item.az;
		vert_s1[0] <= in_item.ax;
		vert_s1[1] <= in_item.ay;
		vert_s1[2] <= in_item.bx;
		vert_s1[3] <= in_item.by_coord;
		vert_s1[4] <= in_item.cx;
		vert_s1[5] <= in_item.cy;
		face_id_s1 <= in_item.face_id;
		depth_ok_s1 <= (da_s1_next >= tcs_pkg::DEPTH_MIN) && (db_s1_next >= tcs_pkg::DEPTH_MIN)
			&& (dc_s1_next >= tcs_pkg::DEPTH_MIN);
	end

	// stage 2: cross terms, projection numerators, depth sum
	logic signed [49:0] pr_s2 [6];
	logic signed [48:0] num_s2 [6];
	logic signed [26:0] dsum_s2;
	logic signed [24:0] dep_s2 [3];
	logic signed [24:0] ax_s2, ay_s2;

	always_ff @(posedge clk) begin
		pr_s2[0] <= v1y_s1 * v2z_s1;
		pr_s2[1] <= v1z_s1 * v2y_s1;
		pr_s2[2] <= v1z_s1 * v2x_s1;
		pr_s2[3] <= v1x_s1 * v2z_s1;
		pr_s2[4] <= v1x_s1 * v2y_s1;
		pr_s2[5] <= v1y_s1 * v2x_s1;
		for (int k = 0; k < 6; k++) begin
			num_s2[k] <= vert_s1[k] * $signed({1'b0, focal_length_q});
		end
		dsum_s2  <= da_s1 + db_s1 + dc_s1;
		dep_s2[0] <= da_s1;
		dep_s2[1] <= db_s1;
		dep_s2[2] <= dc_s1;
		ax_s2    <= vert_s1[0];
		ay_s2    <= vert_s1[1];
	end

	// stage 3: normal, numerator magnitudes, mean reciprocal product
	logic signed [50:0] n_s3 [3];
	logic [46:0]        nmag_s3 [6];
	logic               nsgn_s3 [6];
	logic [50:0]        mprod_s3;
	logic signed [24:0] dep_s3 [3];
	logic signed [24:0] a_s3 [3];

	always_ff @(posedge clk) begin
		n_s3[0] <= pr_s2[0] - pr_s2[1];
		n_s3[1] <= pr_s2[2] - pr_s2[3];
		n_s3[2] <= pr_s2[4] - pr_s2[5];
		for (int k = 0; k < 6; k++) begin
			nmag_s3[k] <= num_s2[k][48] ? 47'(-num_s2[k]) : num_s2[k][46:0];
			nsgn_s3[k] <= num_s2[k][48];
		end
		mprod_s3 <= 51'(dsum_s2[24:0]) * 51'(tcs_pkg::MEAN_RECIP);
		dep_s3   <= dep_s2;
		a_s3[0]  <= ax_s2;
		a_s3[1]  <= ay_s2;
		a_s3[2]  <= dep_s2[0];
	end

	// mean depth
	logic [23:0] mean_s4, mean_s59;

	always_ff @(posedge clk) begin
		mean_s4 <= (mprod_s3[50:27] > tcs_pkg::MEAN_MAX) ? tcs_pkg::MEAN_MAX : mprod_s3[50:27];
	end

	tcs_delay #(.W(24), .D(LAST - 1 - 4)) u_mean_dly (
		.clk(clk), .din(mean_s4), .dout(mean_s59));

	// projection lanes
	logic signed [63:0] cen_x, cen_y;
	logic [15:0]        proj_s59 [6];

	always_comb begin
		cen_x = 64'(SCREEN_WIDTH / 2) + {{53{x_offset_q[10]}}, x_offset_q};
		cen_y = 64'(SCREEN_HEIGHT / 2) + {{53{y_offset_q[10]}}, y_offset_q};
	end

	for (genvar k = 0; k < 6; k++) begin : g_proj
		logic [PQ_W-1:0]    qmag;
		logic               qsgn;
		logic signed [35:0] q_s39;
		logic [41:0]        plo_s40;
		logic signed [42:0] phi_s40;
		logic signed [63:0] t_s41;
		logic [15:0]        p_s42;
		logic signed [63:0] cen;
		logic signed [63:0] tr;
		logic signed [63:0] w;

		assign cen = (k % 2 == 0) ? cen_x : cen_y;

		tcs_div #(.NW(47), .DW(24), .QW(PQ_W)) u_div (
			.clk(clk), .num(nmag_s3[k]), .den(dep_s3[k/2][23:0]), .quo(qmag));

		tcs_delay #(.W(1), .D(PQ_W)) u_sgn_dly (
			.clk(clk), .din(nsgn_s3[k]), .dout(qsgn));

		always_comb begin
			tr = t_s41[63] ? t_s41 + 64'sh0000_0000_FFFF_FFFF : t_s41;
			w  = tr >>> 32;
		end

		always_ff @(posedge clk) begin
			q_s39   <= qsgn ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
			plo_s40 <= 42'(q_s39[17:0]) * 42'(scale_q);
			phi_s40 <= $signed(q_s39[35:18]) * $signed({1'b0, scale_q});
			t_s41   <= ({{21{phi_s40[42]}}, phi_s40} <<< 18) + {22'd0, plo_s40}
				+ (cen <<< 32) + 64'sh0000_0000_8000_0000;
			if (w > 64'sd32767) begin
				p_s42 <= 16'h7FFF;
			end else if (w < -64'sd32768) begin
				p_s42 <= 16'h8000;
			end else begin
				p_s42 <= w[15:0];
			end
		end

		tcs_delay #(.W(16), .D(LAST - 1 - S_PROJ)) u_out_dly (
			.clk(clk), .din(p_s42), .dout(proj_s59[k]));
	end

	// stage 4: normal magnitudes, dot partial products
	logic [50:0]        nm_s4 [3];
	logic               nsg_s4 [3];
	logic signed [51:0] dlo_s4 [3];
	logic signed [49:0] dhi_s4 [3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			nm_s4[k]  <= n_s3[k][50] ? 51'(-n_s3[k]) : n_s3[k];
			nsg_s4[k] <= n_s3[k][50];
			dlo_s4[k] <= $signed({1'b0, n_s3[k][25:0]}) * a_s3[k];
			dhi_s4[k] <= $signed(n_s3[k][50:26]) * a_s3[k];
		end
	end

	// stage 5: largest component, dot terms
	logic [50:0]        mx_s5;
	logic [50:0]        nm_s5 [3];
	logic               nsg_s5 [3];
	logic signed [77:0] dt_s5 [3];
	logic [50:0]        mx01;

	assign mx01 = (nm_s4[1] > nm_s4[0]) ? nm_s4[1] : nm_s4[0];

	always_ff @(posedge clk) begin
		mx_s5  <= (nm_s4[2] > mx01) ? nm_s4[2] : mx01;
		nm_s5  <= nm_s4;
		nsg_s5 <= nsg_s4;
		for (int k = 0; k < 3; k++) begin
			dt_s5[k] <= ({{2{dhi_s4[k][49]}}, dhi_s4[k], 26'd0})
				+ {{26{dlo_s4[k][51]}}, dlo_s4[k]};
		end
	end

	// stage 6: shift count, dot sum
	logic [4:0]         sh_s6;
	logic [50:0]        nm_s6 [3];
	logic               nsg_s6 [3];
	logic signed [79:0] dsum_s6;
	logic               depth_ok_s6;
	logic [5:0]         msb;

	always_comb begin
		msb = '0;
		for (int i = 0; i < 51; i++) begin
			if (mx_s5[i]) begin
				msb = 6'(i);
			end
		end
	end

	tcs_delay #(.W(1), .D(5)) u_dok_dly (
		.clk(clk), .din(depth_ok_s1), .dout(depth_ok_s6));

	always_ff @(posedge clk) begin
		sh_s6   <= (msb >= 6'd30) ? 5'(msb - 6'd29) : 5'd0;
		nm_s6   <= nm_s5;
		nsg_s6  <= nsg_s5;
		dsum_s6 <= 80'(dt_s5[0]) + 80'(dt_s5[1]) + 80'(dt_s5[2]);
	end

	// stage 7: shrunk normal, cull decision
	logic [29:0]        smag_s7 [3];
	logic signed [30:0] sv_s7 [3];
	logic               shnz_s7;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			smag_s7[k] <= 30'(nm_s6[k] >> sh_s6);
			sv_s7[k]   <= nsg_s6[k] ? -$signed({1'b0, 30'(nm_s6[k] >> sh_s6)})
				: $signed({1'b0, 30'(nm_s6[k] >> sh_s6)});
		end
		shnz_s7 <= (sh_s6 != 5'd0);
		cull_s7 <= !depth_ok_s6 || dsum_s6[79] || (dsum_s6 == '0);
	end

	// stage 8: squares and light products
	logic [59:0]        sqt_s8 [3];
	logic signed [47:0] lt_s8 [3];
	logic               shnz_s8;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			sqt_s8[k] <= 60'(smag_s7[k]) * 60'(smag_s7[k]);
		end
		lt_s8[0] <= sv_s7[0] * tcs_pkg::LIGHT_X;
		lt_s8[1] <= sv_s7[1] * tcs_pkg::LIGHT_Y;
		lt_s8[2] <= sv_s7[2] * tcs_pkg::LIGHT_Z;
		shnz_s8  <= shnz_s7;
	end

	// stage 9: length squared, n.L, light-term enable
	logic [61:0]        sq_sum;
	logic signed [49:0] nl_sum;
	logic [61:0]        sq_s9;
	logic [47:0]        nl_s9;
	logic               ok_s9;

	always_comb begin
		sq_sum = 62'(sqt_s8[0]) + 62'(sqt_s8[1]) + 62'(sqt_s8[2]);
		nl_sum = 50'(lt_s8[0]) + 50'(lt_s8[1]) + 50'(lt_s8[2]);
	end

	always_ff @(posedge clk) begin
		sq_s9 <= sq_sum;
		nl_s9 <= nl_sum[47:0];
		ok_s9 <= (shnz_s8 || (sq_sum > tcs_pkg::TINY_SQ)) && !nl_sum[49] && (nl_sum != '0);
	end

	logic [tcs_pkg::LEN_W-1:0] len_s40;
	logic [47:0]               nl_s40;
	logic [DL_W-1:0]           dl_s58;
	logic                      ok_s58;

	tcs_isqrt u_isqrt (.clk(clk), .sq(sq_s9), .root(len_s40));

	tcs_delay #(.W(48), .D(S_LEN - 9)) u_nl_dly (
		.clk(clk), .din(nl_s9), .dout(nl_s40));

	tcs_delay #(.W(1), .D(S_DL - 9)) u_ok_dly (
		.clk(clk), .din(ok_s9), .dout(ok_s58));

	tcs_div #(.NW(48), .DW(tcs_pkg::LEN_W), .QW(DL_W)) u_light_div (
		.clk(clk), .num(nl_s40), .den(len_s40), .quo(dl_s58));

	// stage 59: brightness
	logic [17:0] bright_s59;
	logic [33:0] bprod;

	assign bprod = 34'(tcs_pkg::BRIGHT_GAIN) * 34'(dl_s58);

	always_ff @(posedge clk) begin
		bright_s59 <= ok_s58 ? tcs_pkg::BRIGHT_BASE + bprod[33:16] : tcs_pkg::BRIGHT_BASE;
	end

	logic [15:0] face_id_s59;

	tcs_delay #(.W(16), .D(LAST - 2)) u_id_dly (
		.clk(clk), .din(face_id_s1), .dout(face_id_s59));

	// stage 60: shade channels and assemble the transaction
	logic [22:0]      rprod, bprod_c;
	logic [23:0]      gprod;
	logic [4:0]       rch, bch;
	logic [5:0]       gch;
	tcs_pkg::result_t result_s60;

	always_comb begin
		rprod   = 23'(base_color_q[15:11]) * 23'(bright_s59);
		gprod   = 24'(base_color_q[10:5]) * 24'(bright_s59);
		bprod_c = 23'(base_color_q[4:0]) * 23'(bright_s59);
		rch = (rprod[22:16] > 7'd31) ? 5'd31 : rprod[20:16];
		gch = (gprod[23:16] > 8'd63) ? 6'd63 : gprod[21:16];
		bch = (bprod_c[22:16] > 7'd31) ? 5'd31 : bprod_c[20:16];
	end

	always_ff @(posedge clk) begin
		result_s60.tri_id       <= face_id_s59;
		result_s60.pax          <= proj_s59[0];
		result_s60.pay          <= proj_s59[1];
		result_s60.pbx          <= proj_s59[2];
		result_s60.pby          <= proj_s59[3];
		result_s60.pcx          <= proj_s59[4];
		result_s60.pcy          <= proj_s59[5];
		result_s60.mean_depth   <= mean_s59;
		result_s60.shaded_color <= {rch, gch, bch};
	end

	assign done   = valid_s[LAST];
	assign result = result_s60;

endmodule

// ----- hw/rtl/tcs_checker.sv -----
// Port-level checker for the triangle pipeline, bound to the top level.
module tcs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input tcs_pkg::in_item_t in_item,
	input logic              done,
	input tcs_pkg::result_t  result
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised");

	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 60)) else $error("result without a start");

	a_tag_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.tri_id == $past(in_item.face_id, 60)))
		else $error("result tag mismatch");

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!result.mean_depth[23] && (result.mean_depth >= 24'sd6554)))
		else $error("mean depth below near limit");

endmodule

bind triangle_cull_shade_project tcs_checker u_tcs_checker (.*);

// ----- bench/tb_triangle_cull_shade_project.sv -----
// Self-checking bench for the triangle cull, shade and projection pipeline.
module tb_triangle_cull_shade_project;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW = 240;
	localparam int SH = 320;
	localparam int LATENCY = 60;
	localparam int WATCHDOG = 20000;

	class tri_scoreboard;
		tcs_pkg::result_t pending[$];
		int mismatches;
		int failures;
		logic [23:0] focal;
		logic [23:0] scl;
		logic signed [10:0] xoff;
		logic signed [10:0] yoff;
		logic [15:0] color;

		function new();
			focal = tcs_pkg::FOCAL_RESET;
			scl = tcs_pkg::SCALE_RESET;
			xoff = 0;
			yoff = 0;
			color = tcs_pkg::COLOR_RESET;
		endfunction

		function void write_reg(tcs_pkg::cfg_idx_t idx, logic [23:0] v);
			case (idx)
				tcs_pkg::CFG_FOCAL: focal = v;
				tcs_pkg::CFG_SCALE: scl = v;
				tcs_pkg::CFG_X_OFFSET: xoff = v[10:0];
				tcs_pkg::CFG_Y_OFFSET: yoff = v[10:0];
				tcs_pkg::CFG_BASE: color = v[15:0];
				default: ;
			endcase
		endfunction

		function logic [15:0] screen_coord(longint c, longint depth, longint center);
			longint q, t, p;
			q = (c * longint'(focal)) / depth;
			t = q * longint'(scl) + center * 64'sd4294967296 + 64'sd2147483648;
			p = t / 64'sd4294967296;
			if (p > 32767) p = 32767;
			if (p < -32768) p = -32768;
			return p[15:0];
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > v) bitv >>= 2;
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v -= res + bitv;
					res = (res >> 1) + bitv;
				end else res >>= 1;
				bitv >>= 2;
			end
			return res;
		endfunction

		function longint shrink_mag(longint v, int s);
			longint unsigned m;
			m = (v < 0 ? -v : v);
			m = m >> s;
			return v < 0 ? -longint'(m) : longint'(m);
		endfunction

		function void note_triangle(tcs_pkg::in_item_t it);
			longint ax, ay, bx, by, cx, cy, da, db, dc;
			longint v1x, v1y, v1z, v2x, v2y, v2z, nx, ny, nz, sx, sy, sz, nl;
			logic signed [127:0] dot;
			longint unsigned mx, sq, bright, r, g, b, len, dl, mean;
			int s;
			tcs_pkg::result_t e;
			ax = it.ax; ay = it.ay; bx = it.bx; by = it.by_coord; cx = it.cx; cy = it.cy;
			da = longint'(it.az) + 327680;
			db = longint'(it.bz) + 327680;
			dc = longint'(it.cz) + 327680;
			if (da < 6554 || db < 6554 || dc < 6554) return;
			v1x = bx - ax; v1y = by - ay; v1z = db - da;
			v2x = cx - ax; v2y = cy - ay; v2z = dc - da;
			nx = v1y * v2z - v1z * v2y;
			ny = v1z * v2x - v1x * v2z;
			nz = v1x * v2y - v1y * v2x;
			dot = 128'(signed'(nx)) * 128'(signed'(ax)) + 128'(signed'(ny)) * 128'(signed'(ay))
				+ 128'(signed'(nz)) * 128'(signed'(da));
			if (dot <= 0) return;
			mx = nx < 0 ? -nx : nx;
			if ((ny < 0 ? -ny : ny) > mx) mx = ny < 0 ? -ny : ny;
			if ((nz < 0 ? -nz : nz) > mx) mx = nz < 0 ? -nz : nz;
			s = 0;
			while ((mx >> s) >= (64'd1 << 30)) s++;
			sx = shrink_mag(nx, s); sy = shrink_mag(ny, s); sz = shrink_mag(nz, s);
			sq = sx * sx + sy * sy + sz * sz;
			bright = 16384;
			if (s > 0 || sq > 64'd184467440737) begin
				len = int_sqrt(sq);
				nl = sx * 39126 + sy * (-26084) + sz * 45648;
				if (nl > 0 && len > 0) begin
					dl = nl / longint'(len);
					bright = 16384 + ((49152 * dl) >> 16);
				end
			end
			r = (longint'(color[15:11]) * bright) >> 16;
			g = (longint'(color[10:5]) * bright) >> 16;
			b = (longint'(color[4:0]) * bright) >> 16;
			if (r > 31) r = 31;
			if (g > 63) g = 63;
			if (b > 31) b = 31;
			mean = longint'(da + db + dc) / 3;
			if (mean > 8388607) mean = 8388607;
			e.tri_id = it.face_id;
			e.pax = screen_coord(ax, da, SW / 2 + xoff);
			e.pay = screen_coord(ay, da, SH / 2 + yoff);
			e.pbx = screen_coord(bx, db, SW / 2 + xoff);
			e.pby = screen_coord(by, db, SH / 2 + yoff);
			e.pcx = screen_coord(cx, dc, SW / 2 + xoff);
			e.pcy = screen_coord(cy, dc, SH / 2 + yoff);
			e.mean_depth = mean[23:0];
			e.shaded_color = {r[4:0], g[5:0], b[4:0]};
			pending.push_back(e);
		endfunction

		function void check_result(tcs_pkg::result_t got);
			tcs_pkg::result_t e;
			if (pending.size() == 0) begin
				failures++;
				if (mismatches++ < 10) $display("unexpected result %h", got);
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				failures++;
				if (mismatches++ < 10) $display("mismatch id %0d: expected %h actual %h",
					e.tri_id, e, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	tcs_pkg::in_item_t in_item = '0;
	logic cfg_we = 0;
	logic [tcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tcs_pkg::CFG_W-1:0] cfg_data = '0;
	logic done;
	tcs_pkg::result_t result;

	tri_scoreboard sb = new();
	int idle_pct;
	int quiet;

	triangle_cull_shade_project u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .result(result)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (done) sb.check_result(result);
		if ((start && !busy) || done) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > WATCHDOG) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_triangle(tcs_pkg::in_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		in_item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_triangle(it);
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	// hold the write enable; the caller drops it after the last write
	task automatic write_reg(tcs_pkg::cfg_idx_t idx, logic [23:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	function automatic logic [23:0] small_coord();
		return 24'($signed($urandom_range(0, 262143)) - 131072);
	endfunction

	function automatic tcs_pkg::in_item_t rand_triangle();
		tcs_pkg::in_item_t it;
		logic [255:0] rnd;
		it.face_id = 16'($urandom);
		if ($urandom_range(9) == 0) begin
			rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom};
			it = rnd[$bits(tcs_pkg::in_item_t)-1:0];
		end else begin
			it.ax = small_coord(); it.ay = small_coord(); it.az = small_coord();
			it.bx = small_coord(); it.by_coord = small_coord(); it.bz = small_coord();
			it.cx = small_coord(); it.cy = small_coord(); it.cz = small_coord();
			if ($urandom_range(3) == 0) begin
				it.az = 24'($signed($urandom_range(0, 600000)) - 327680);
				it.bz = 24'($signed($urandom_range(0, 600000)) - 327680);
			end
		end
		return it;
	endfunction

	task automatic config_phase(int k);
		write_reg(tcs_pkg::CFG_FOCAL,
			k == 0 ? 24'hFFFFFF : k == 1 ? 24'd0 : 24'($urandom_range(0, 500000)));
		write_reg(tcs_pkg::CFG_SCALE,
			k == 0 ? 24'hFFFFFF : k == 2 ? 24'd0 : 24'($urandom_range(0, 500000)));
		write_reg(tcs_pkg::CFG_X_OFFSET, k == 0 ? 24'h3FF : k == 1 ? 24'h400 : 24'($urandom));
		write_reg(tcs_pkg::CFG_Y_OFFSET, k == 0 ? 24'h400 : k == 1 ? 24'h3FF : 24'($urandom));
		write_reg(tcs_pkg::CFG_BASE, k == 0 ? 24'h0 : k == 1 ? 24'hFFFF : 24'($urandom));
		cfg_we <= 0;
	endtask

	initial begin
		tcs_pkg::in_item_t it;
		idle_pct = 36;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		it = '0; it.face_id = 16'hFFFF; it.bx = 24'h010000; it.cy = 24'h010000;
		send_triangle(it);
		it = '0; it.face_id = 1; it.by_coord = 24'h010000; it.cx = 24'h010000;
		send_triangle(it);
		it = '0; it.face_id = 2; it.az = 24'h800000;
		send_triangle(it);
		it = '0; it.face_id = 3; it.az = -24'sd321126; it.bz = -24'sd321126; it.cz = -24'sd321126;
		it.bx = 24'h10; it.cy = 24'h10;
		send_triangle(it);
		it = '0; it.face_id = 4; it.bx = 1; it.cy = 1;
		send_triangle(it);
		it = {16'h5, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
			24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF};
		send_triangle(it);
		it = '1;
		send_triangle(it);
		it = '0; it.face_id = 6; it.ax = 24'h7FFFFF; it.bx = 24'h800000; it.cy = 24'h7FFFFF;
		it.az = -24'sd300000; it.bz = -24'sd300000; it.cz = -24'sd300000;
		send_triangle(it);
		for (int i = 0; i < 8; i++) send_triangle(rand_triangle());
		drain();
		for (int k = 0; k < 5; k++) begin
			config_phase(k);
			if (k == 2) idle_pct = 87;
			if (k == 4) idle_pct = 0;
			for (int i = 0; i < 100; i++) send_triangle(rand_triangle());
			drain();
		end
		if (sb.failures == 0 && sb.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

// ----- triangle_cull_shade_project.f -----
hw/rtl/tcs_pkg.sv
hw/rtl/tcs_delay.sv
hw/rtl/tcs_div.sv
hw/rtl/tcs_isqrt.sv
hw/rtl/triangle_cull_shade_project.sv
hw/rtl/tcs_checker.sv
bench/tb_triangle_cull_shade_project.sv
